[design/session_table_with_idle_aging_macros.svh]
// Assertion macros for the session table with idle aging.
`ifndef SESSION_TABLE_WITH_IDLE_AGING_MACROS_SVH
`define SESSION_TABLE_WITH_IDLE_AGING_MACROS_SVH
// Check that a condition implies a condition in the next cycle.
`define STA_ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("lbl failed");
// Check that a condition holds in every cycle.
`define STA_ASSERT_ALWAYS(lbl, clk, rst, a) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a)) \
    else $error("lbl failed");
`endif

[design/sta_pkg.sv]
// Package with command, status and session state codes.
`default_nettype none
package sta_pkg;
  localparam logic [2:0] CMD_CREATE   = 3'd0;
  localparam logic [2:0] CMD_LOOKUP   = 3'd1;
  localparam logic [2:0] CMD_REMOVE   = 3'd2;
  localparam logic [2:0] CMD_ACTIVITY = 3'd3;
  localparam logic [2:0] CMD_SETPROTO = 3'd4;
  localparam logic [2:0] CMD_SWEEP    = 3'd5;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_NOTFOUND = 2'd2;
  localparam logic [1:0] STAT_ZEROKEY  = 2'd3;

  localparam logic [2:0] ST_CONNECTED = 3'd0;
  localparam logic [2:0] ST_ACTIVE    = 3'd2;
  localparam logic [2:0] ST_CLOSED    = 3'd4;

  localparam logic [15:0] IDLE_RESET = 16'd60;

  typedef enum logic [2:0] {
    S_IDLE, S_CLEAR, S_SCAN, S_APPLY, S_RESP
  } ctl_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture an input beat
    logic clr_step;  // clear one slot in the reset pass
    logic scan_step; // examine one slot
    logic apply;     // update the table and build the result
    logic out_valid;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic scan_done;
  } dp_stat_t;
endpackage
`default_nettype wire

[design/sta_stream_if.sv]
// Valid/ready channel interface carrying a payload.
`default_nettype none
interface sta_stream_if #(parameter int W = 8);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

[design/session_table_with_idle_aging.sv]
// Usage: session table with idle aging, top level.
// Input channel "req" carries cmd, conn_key, proto and now_seconds; output
// channel "rsp" carries one result beat per request: status, slot,
// sess_state, sess_proto, msg_total and closed_count.
// Each request scans all SLOTS slots one per cycle through a single slot
// read port, then an update step, then the result is held.
// One request is in flight at a time; req.ready is low until the result is
// taken. A stalled receiver holds the result and the table unchanged.
// After reset a clearing pass over all SLOTS slots empties the table before
// the first request is accepted; idle_limit returns to 60. The user writes
// idle_limit via cfg_we/cfg_data only while idle, unchecked by the block.
`default_nettype none
`include "session_table_with_idle_aging_macros.svh"
module session_table_with_idle_aging #(
  parameter int SLOTS = 16
) (
  input wire logic clk,
  input wire logic rst,
  sta_stream_if.sink   req,
  sta_stream_if.source rsp,
  input wire logic cfg_we,
  input wire logic [15:0] cfg_data
);
  import sta_pkg::*;
  dp_cmd_t  dcmd;
  dp_stat_t dstat;
  logic [15:0] idle_limit;

  always_ff @(posedge clk) begin
    if (rst) idle_limit <= IDLE_RESET;
    else if (cfg_we) idle_limit <= cfg_data;
  end

  sta_ctrl u_ctrl (
    .clk, .rst, .in_valid(req.valid), .in_ready(req.ready),
    .out_ready(rsp.ready), .stat(dstat), .cmd(dcmd)
  );

  sta_datapath #(.SLOTS(SLOTS)) u_dp (
    .clk, .rst, .cmd(dcmd), .stat(dstat), .idle_limit,
    .in_cmd(req.data[53:51]), .in_key(req.data[50:35]),
    .in_proto(req.data[34:32]), .in_now(req.data[31:0]),
    .status(rsp.data[48:47]), .slot(rsp.data[46:43]),
    .sess_state(rsp.data[42:40]), .sess_proto(rsp.data[39:37]),
    .msg_total(rsp.data[36:5]), .closed_count(rsp.data[4:0])
  );

  assign rsp.valid = dcmd.out_valid;

  `STA_ASSERT_ALWAYS(a_one_side, clk, rst, !(req.ready && rsp.valid))
  `STA_ASSERT_NEXT(a_load_busy, clk, rst, req.valid && req.ready, !req.ready)
  `STA_ASSERT_NEXT(a_hold, clk, rst, rsp.valid && !rsp.ready, rsp.valid)
endmodule
`default_nettype wire

[design/sta_ctrl.sv]
// Controller state machine sequencing clear pass, slot scan and update.
`default_nettype none
module sta_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic out_ready,
  input  wire sta_pkg::dp_stat_t stat,
  output sta_pkg::dp_cmd_t cmd
);
  import sta_pkg::*;
  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) state_next = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        cmd.out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[design/sta_datapath.sv]
// Slot table storage, sequential slot scan and command execution.
`default_nettype none
module sta_datapath #(
  parameter int SLOTS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire sta_pkg::dp_cmd_t cmd,
  output sta_pkg::dp_stat_t stat,
  input  wire logic [15:0] idle_limit,
  input  wire logic [2:0]  in_cmd,
  input  wire logic [15:0] in_key,
  input  wire logic [2:0]  in_proto,
  input  wire logic [31:0] in_now,
  output logic [1:0]  status,
  output logic [3:0]  slot,
  output logic [2:0]  sess_state,
  output logic [2:0]  sess_proto,
  output logic [31:0] msg_total,
  output logic [4:0]  closed_count
);
  import sta_pkg::*;
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  // Slot fields, one register per slot field word
  logic [15:0] key_mem  [SLOTS];
  logic        act_mem  [SLOTS];
  logic [2:0]  prot_mem [SLOTS];
  logic [2:0]  st_mem   [SLOTS];
  logic [31:0] seen_mem [SLOTS];
  logic [31:0] msgs_mem [SLOTS];

  logic [CW-1:0] live_count;
  logic [IW-1:0] idx;
  logic [2:0]  r_cmd;
  logic [15:0] r_key;
  logic [2:0]  r_proto;
  logic [31:0] r_now;
  logic        found;
  logic [IW-1:0] hit;
  logic [4:0]  closed;

  // read of the slot under scan
  logic [15:0] k_i;
  logic        a_i;
  logic [31:0] l_i;
  logic        match_i, need_act, zero_key, last;
  logic [31:0] age;

  // read of the matched slot and the result it yields
  logic [2:0]  hit_state;
  logic [2:0]  hit_proto;
  logic [31:0] hit_msgs;
  logic        full, ok_hit;
  logic [1:0]  res_status;
  logic [3:0]  res_slot;
  logic [2:0]  res_state;
  logic [2:0]  res_proto;
  logic [31:0] res_msgs;
  logic [4:0]  res_closed;

  assign k_i = key_mem[idx];
  assign a_i = act_mem[idx];
  assign l_i = seen_mem[idx];
  assign age = r_now - l_i;
  assign need_act = (r_cmd == CMD_LOOKUP) || (r_cmd == CMD_ACTIVITY);
  assign match_i = (r_cmd == CMD_CREATE) ? (k_i == 16'd0)
                 : ((k_i == r_key) && (!need_act || a_i));
  assign zero_key = (r_cmd <= CMD_SETPROTO) && (r_key == 16'd0);
  assign last = (idx == IW'(SLOTS - 1));
  assign stat.scan_done = last;
  assign stat.clr_done = last;

  assign hit_state = st_mem[hit];
  assign hit_proto = prot_mem[hit];
  assign hit_msgs = msgs_mem[hit];
  assign full = (live_count >= CW'(SLOTS));
  assign ok_hit = (r_cmd <= CMD_SETPROTO) && !zero_key && found &&
                  !((r_cmd == CMD_CREATE) && full);
  assign res_slot = ok_hit ? 4'(hit) : 4'd0;

  always_comb begin
    res_status = STAT_OK;
    res_state = '0;
    res_proto = '0;
    res_msgs = '0;
    res_closed = '0;
    if (zero_key) res_status = STAT_ZEROKEY;
    else if (r_cmd == CMD_SWEEP) res_closed = closed;
    else if (r_cmd <= CMD_SETPROTO) begin
      if (!ok_hit) begin
        res_status = (r_cmd == CMD_CREATE) ? STAT_FULL : STAT_NOTFOUND;
      end else begin
        case (r_cmd)
          CMD_CREATE: begin
            res_state = (r_proto == 3'd0) ? ST_CONNECTED : ST_ACTIVE;
            res_proto = r_proto;
          end
          CMD_LOOKUP: begin
            res_state = hit_state;
            res_proto = hit_proto;
            res_msgs = hit_msgs;
          end
          CMD_REMOVE: begin
            res_state = ST_CLOSED;
            res_proto = hit_proto;
            res_msgs = hit_msgs;
          end
          CMD_ACTIVITY: begin
            res_state = (hit_proto != 3'd0 && hit_state == ST_CONNECTED) ? ST_ACTIVE
                      : hit_state;
            res_proto = hit_proto;
            res_msgs = hit_msgs + 32'd1;
          end
          CMD_SETPROTO: begin
            res_state = (r_proto != 3'd0 && hit_proto == 3'd0) ? ST_ACTIVE : hit_state;
            res_proto = r_proto;
            res_msgs = hit_msgs;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      live_count <= '0;
    end else if (cmd.clr_step) begin
      idx <= last ? '0 : idx + IW'(1);
      key_mem[idx] <= '0; act_mem[idx] <= 1'b0; prot_mem[idx] <= '0;
      st_mem[idx] <= '0; seen_mem[idx] <= '0; msgs_mem[idx] <= '0;
    end else if (cmd.load) begin
      r_cmd <= in_cmd; r_key <= in_key; r_proto <= in_proto; r_now <= in_now;
      idx <= '0;
      found <= 1'b0;
      closed <= '0;
    end else if (cmd.scan_step) begin
      idx <= last ? '0 : idx + IW'(1);
      if (r_cmd == CMD_SWEEP) begin
        // close idle active sessions
        if (k_i != 16'd0 && a_i && age > {16'd0, idle_limit}) begin
          st_mem[idx] <= ST_CLOSED;
          closed <= closed + 5'd1;
        end
      end else if (!found && match_i) begin
        found <= 1'b1;
        hit <= idx;
      end
    end else if (cmd.apply) begin
      status <= res_status;
      slot <= res_slot;
      sess_state <= res_state;
      sess_proto <= res_proto;
      msg_total <= res_msgs;
      closed_count <= res_closed;
      if (ok_hit) begin
        case (r_cmd)
          CMD_CREATE: begin
            key_mem[hit] <= r_key; act_mem[hit] <= 1'b1;
            prot_mem[hit] <= r_proto; seen_mem[hit] <= r_now;
            msgs_mem[hit] <= '0;
            st_mem[hit] <= res_state;
            live_count <= live_count + CW'(1);
          end
          CMD_REMOVE: begin
            key_mem[hit] <= '0; act_mem[hit] <= 1'b0; prot_mem[hit] <= '0;
            st_mem[hit] <= '0; seen_mem[hit] <= '0; msgs_mem[hit] <= '0;
            if (live_count != '0) live_count <= live_count - CW'(1);
          end
          CMD_ACTIVITY: begin
            seen_mem[hit] <= r_now;
            msgs_mem[hit] <= res_msgs;
            st_mem[hit] <= res_state;
          end
          CMD_SETPROTO: begin
            prot_mem[hit] <= r_proto;
            st_mem[hit] <= res_state;
          end
          default: ;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

[tb/session_table_checker.sv]
// Checker for the session table: predicts each result beat and compares it.
`timescale 1ns / 1ps
module session_table_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_ready,
  input  logic [53:0] req_data,
  input  logic        rsp_valid,
  input  logic        rsp_ready,
  input  logic [48:0] rsp_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending_count
);
  import sta_pkg::*;
  localparam int NSLOT = 16;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot;
    logic [2:0]  sess_state;
    logic [2:0]  sess_proto;
    logic [31:0] msg_total;
    logic [4:0]  closed_count;
  } sess_result_t;

  logic [15:0] tbl_key[NSLOT];
  logic        tbl_active[NSLOT];
  logic [2:0]  tbl_proto[NSLOT];
  logic [2:0]  tbl_state[NSLOT];
  logic [31:0] tbl_seen[NSLOT];
  logic [31:0] tbl_msgs[NSLOT];
  int          tbl_live;
  logic [15:0] limit_secs;
  sess_result_t result_q[$];

  function automatic int find_slot(logic [15:0] key, bit need_active);
    for (int i = 0; i < NSLOT; i++)
      if (tbl_key[i] == key && (!need_active || tbl_active[i])) return i;
    return -1;
  endfunction

  function automatic void clear_slot(int i);
    tbl_key[i] = '0; tbl_active[i] = 1'b0; tbl_proto[i] = '0;
    tbl_state[i] = '0; tbl_seen[i] = '0; tbl_msgs[i] = '0;
  endfunction

  function automatic void fill_slot_fields(ref sess_result_t r, input int i);
    r.slot = i[3:0];
    r.sess_state = tbl_state[i];
    r.sess_proto = tbl_proto[i];
    r.msg_total = tbl_msgs[i];
  endfunction

  function automatic sess_result_t apply_command(logic [2:0] cmd, logic [15:0] key,
                                                 logic [2:0] proto, logic [31:0] now);
    sess_result_t r;
    int i;
    logic [4:0] closed;
    r = '0;
    if (cmd <= CMD_SETPROTO && key == 16'd0) begin
      r.status = STAT_ZEROKEY;
      return r;
    end
    case (cmd)
      CMD_CREATE: begin
        i = (tbl_live >= NSLOT) ? -1 : find_slot(16'd0, 1'b0);
        if (i < 0) begin
          r.status = STAT_FULL;
        end else begin
          tbl_key[i] = key; tbl_active[i] = 1'b1; tbl_proto[i] = proto;
          tbl_state[i] = (proto == 3'd0) ? ST_CONNECTED : ST_ACTIVE;
          tbl_seen[i] = now; tbl_msgs[i] = '0;
          tbl_live++;
          fill_slot_fields(r, i);
        end
      end
      CMD_LOOKUP: begin
        i = find_slot(key, 1'b1);
        if (i < 0) r.status = STAT_NOTFOUND;
        else fill_slot_fields(r, i);
      end
      CMD_REMOVE: begin
        i = find_slot(key, 1'b0);
        if (i < 0) begin
          r.status = STAT_NOTFOUND;
        end else begin
          fill_slot_fields(r, i);
          r.sess_state = ST_CLOSED;
          clear_slot(i);
          if (tbl_live > 0) tbl_live--;
        end
      end
      CMD_ACTIVITY: begin
        i = find_slot(key, 1'b1);
        if (i < 0) begin
          r.status = STAT_NOTFOUND;
        end else begin
          tbl_seen[i] = now;
          tbl_msgs[i] = tbl_msgs[i] + 32'd1;
          if (tbl_proto[i] != 3'd0 && tbl_state[i] == ST_CONNECTED)
            tbl_state[i] = ST_ACTIVE;
          fill_slot_fields(r, i);
        end
      end
      CMD_SETPROTO: begin
        i = find_slot(key, 1'b0);
        if (i < 0) begin
          r.status = STAT_NOTFOUND;
        end else begin
          if (proto != 3'd0 && tbl_proto[i] == 3'd0) tbl_state[i] = ST_ACTIVE;
          tbl_proto[i] = proto;
          fill_slot_fields(r, i);
        end
      end
      CMD_SWEEP: begin
        closed = '0;
        for (int j = 0; j < NSLOT; j++) begin
          // idle time wraps modulo 2^32
          if (tbl_key[j] != 16'd0 && tbl_active[j] &&
              (now - tbl_seen[j]) > {16'd0, limit_secs}) begin
            tbl_state[j] = ST_CLOSED;
            closed++;
          end
        end
        r.closed_count = closed;
      end
      default: ;
    endcase
    return r;
  endfunction

  assign pending_count = result_q.size();

  always @(posedge clk) begin
    sess_result_t exp_r, got_r;
    if (rst) begin
      for (int i = 0; i < NSLOT; i++) clear_slot(i);
      tbl_live = 0;
      limit_secs = IDLE_RESET;
      result_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) limit_secs = cfg_data;
      if (req_valid && req_ready)
        result_q.push_back(apply_command(req_data[53:51], req_data[50:35],
                                         req_data[34:32], req_data[31:0]));
      if (rsp_valid && rsp_ready) begin
        got_r = rsp_data;
        if (result_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result beat %h", got_r);
        end else begin
          exp_r = result_q.pop_front();
          if (got_r !== exp_r) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch: exp st=%0d slot=%0d ss=%0d sp=%0d msgs=%0d cl=%0d",
                exp_r.status, exp_r.slot, exp_r.sess_state, exp_r.sess_proto,
                exp_r.msg_total, exp_r.closed_count);
              $display("          got st=%0d slot=%0d ss=%0d sp=%0d msgs=%0d cl=%0d",
                got_r.status, got_r.slot, got_r.sess_state, got_r.sess_proto,
                got_r.msg_total, got_r.closed_count);
            end
          end
        end
      end
    end
  end
endmodule

[tb/session_table_with_idle_aging_tb.sv]
// Testbench top: stimulus, idle phases and verdict for the session table.
`timescale 1ns / 1ps
module session_table_with_idle_aging_tb;
  import sta_pkg::*;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [15:0] cfg_data;
  int fail_count, pending_count;
  int idle_mode;
  int hold_cycles;
  int cmds_sent, limits_written;
  logic [31:0] clock_secs;

  sta_stream_if #(.W(54)) req();
  sta_stream_if #(.W(49)) rsp();

  session_table_with_idle_aging dut (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  session_table_checker chk (
    .clk(clk), .rst(rst),
    .req_valid(req.valid), .req_ready(req.ready), .req_data(req.data),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver: random stalls per phase, plus a long hold-off on request
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        rsp.ready <= 1'b0;
      end else if (idle_mode == 2) begin
        rsp.ready <= ($urandom_range(0, 99) >= 69);
      end else if (idle_mode == 3) begin
        rsp.ready <= ($urandom_range(0, 99) >= 23);
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  task automatic send_beat(logic [2:0] cmd, logic [15:0] key, logic [2:0] proto,
                           logic [31:0] now);
    int idle_pct;
    idle_pct = (idle_mode == 1) ? 69 : (idle_mode == 3) ? 23 : 0;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      req.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    req.valid <= 1'b1;
    req.data <= {cmd, key, proto, now};
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
    cmds_sent++;
  endtask

  task automatic drain_and_write(logic [15:0] limit);
    req.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (25) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= limit;
    @(negedge clk);
    cfg_we <= 1'b0;
    limits_written++;
  endtask

  task automatic random_beats(int count);
    logic [2:0] cmd;
    logic [15:0] key;
    logic [2:0] proto;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 24) cmd = CMD_CREATE;
      else if (pick < 38) cmd = CMD_LOOKUP;
      else if (pick < 52) cmd = CMD_REMOVE;
      else if (pick < 74) cmd = CMD_ACTIVITY;
      else if (pick < 86) cmd = CMD_SETPROTO;
      else if (pick < 96) cmd = CMD_SWEEP;
      else cmd = 3'($urandom_range(0, 7));
      pick = $urandom_range(0, 99);
      key = (pick < 3) ? 16'd0 : (pick < 10) ? 16'($urandom) : 16'($urandom_range(1, 12));
      proto = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(0, 7));
      // advance time, with an occasional jump anywhere
      if ($urandom_range(0, 49) == 0) clock_secs = $urandom;
      else clock_secs = clock_secs + $urandom_range(0, 40);
      send_beat(cmd, key, proto, clock_secs);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    req.valid = 1'b0;
    req.data = '0;
    idle_mode = 0;
    hold_cycles = 0;
    cmds_sent = 0;
    limits_written = 0;
    clock_secs = 32'hFFFF_FF00;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: zero keys, each command, wrap of time, odd protocols
    send_beat(CMD_CREATE, 16'd0, 3'd1, 32'd0);
    send_beat(CMD_LOOKUP, 16'd0, 3'd0, 32'd0);
    send_beat(CMD_REMOVE, 16'd0, 3'd0, 32'd0);
    send_beat(CMD_ACTIVITY, 16'd0, 3'd0, 32'd0);
    send_beat(CMD_SETPROTO, 16'd0, 3'd2, 32'd0);
    send_beat(CMD_CREATE, 16'hFFFF, 3'd0, 32'hFFFF_FFF0);
    send_beat(CMD_CREATE, 16'd1, 3'd7, 32'hFFFF_FFFF);
    send_beat(CMD_CREATE, 16'd1, 3'd3, 32'd5);
    send_beat(CMD_LOOKUP, 16'd1, 3'd0, 32'd6);
    send_beat(CMD_ACTIVITY, 16'hFFFF, 3'd0, 32'd10);
    send_beat(CMD_SETPROTO, 16'hFFFF, 3'd4, 32'd11);
    send_beat(CMD_ACTIVITY, 16'hFFFF, 3'd0, 32'd12);
    send_beat(CMD_LOOKUP, 16'd2, 3'd0, 32'd13);
    send_beat(CMD_SWEEP, 16'd0, 3'd0, 32'd40);
    send_beat(CMD_SWEEP, 16'hAAAA, 3'd5, 32'd200);
    send_beat(CMD_SWEEP, 16'd0, 3'd0, 32'd300);
    send_beat(3'd6, 16'h5555, 3'd6, 32'h5555_5555);
    send_beat(3'd7, 16'hAAAA, 3'd1, 32'hAAAA_AAAA);
    send_beat(CMD_REMOVE, 16'd1, 3'd0, 32'd301);
    send_beat(CMD_REMOVE, 16'd1, 3'd0, 32'd302);
    send_beat(CMD_REMOVE, 16'd1, 3'd0, 32'd303);
    clock_secs = 32'd400;

    drain_and_write(16'd0);
    random_beats(350);
    idle_mode = 1;
    drain_and_write(16'd65535);
    random_beats(400);
    idle_mode = 2;
    drain_and_write(16'd30);
    random_beats(400);
    idle_mode = 3;
    drain_and_write(16'($urandom_range(1, 120)));
    random_beats(400);
    // long receiver hold-off while requests keep coming
    idle_mode = 0;
    drain_and_write(16'd60);
    hold_cycles = 300;
    random_beats(400);

    req.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    $display("Ran %0d commands over four idle phases and a long receiver hold-off,", cmds_sent);
    $display("with %0d idle limit settings including 0 and 65535.", limits_written);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+design
design/sta_pkg.sv
design/sta_stream_if.sv
design/sta_ctrl.sv
design/sta_datapath.sv
design/session_table_with_idle_aging.sv
tb/session_table_checker.sv
tb/session_table_with_idle_aging_tb.sv
